>>> rtl/core/caf_pkg.sv
// shared constants and types for the cell area fraction block
`timescale 1ns / 1ps

package caf_pkg;

	// default widths of distances and of the coverage fraction
	localparam int CAF_DIST_WIDTH = 24;
	localparam int CAF_FRAC_BITS = 16;

	// depth of the queue between classifier and arithmetic back end
	localparam int CAF_QUEUE_DEPTH = 4;

	// operands per lane: two product pairs for the numerator, one pair for the denominator
	localparam int CAF_LANE_OPS = 6;

	// how the two lane quotients turn into the coverage
	typedef enum logic [1:0] {
		CAF_RK_SUM  = 2'd0,
		CAF_RK_INV  = 2'd1,
		CAF_RK_ZERO = 2'd2,
		CAF_RK_FULL = 2'd3
	} caf_res_kind_t;

	// queue status seen by both sides
	typedef struct packed {
		logic full;
		logic empty;
	} caf_qstat_t;

endpackage

>>> rtl/core/caf_if.sv
// handshake channels for distance items and coverage items
`timescale 1ns / 1ps

interface caf_in_if #(
	parameter int DIST_WIDTH = caf_pkg::CAF_DIST_WIDTH
) ();
	logic valid;
	logic ready;
	logic signed [DIST_WIDTH-1:0] dist_top_left;
	logic signed [DIST_WIDTH-1:0] dist_top_right;
	logic signed [DIST_WIDTH-1:0] dist_bottom_left;
	logic signed [DIST_WIDTH-1:0] dist_bottom_right;

	modport source (
		output valid, dist_top_left, dist_top_right, dist_bottom_left, dist_bottom_right,
		input ready
	);
	modport sink (
		input valid, dist_top_left, dist_top_right, dist_bottom_left, dist_bottom_right,
		output ready
	);
endinterface

interface caf_out_if #(
	parameter int COV_WIDTH = caf_pkg::CAF_FRAC_BITS + 1
) ();
	logic valid;
	logic ready;
	logic [COV_WIDTH-1:0] coverage;

	modport source (output valid, coverage, input ready);
	modport sink (input valid, coverage, output ready);
endinterface

>>> rtl/core/caf_front.sv
// front end: takes a cell item, classifies its inside mask and picks the lane operands
`timescale 1ns / 1ps

module caf_front #(
	parameter int DIST_WIDTH = caf_pkg::CAF_DIST_WIDTH
) (
	input  logic clk,
	input  logic arst_n,
	caf_in_if.sink cell_in,
	input  caf_pkg::caf_qstat_t qstat,
	output logic push,
	output logic [2*caf_pkg::CAF_LANE_OPS*DIST_WIDTH+$bits(caf_pkg::caf_res_kind_t)-1:0] item
);
	import caf_pkg::*;

	localparam int W = DIST_WIDTH;
	localparam int LW = CAF_LANE_OPS * W;
	localparam int KW = $bits(caf_res_kind_t);
	localparam int QW = 2 * LW + KW;
	localparam logic [W-1:0] ONE_W = W'(1);

	// edge length between an outside and an inside corner
	function automatic logic [W-1:0] edge_len(input logic signed [W-1:0] a,
		input logic signed [W-1:0] c, input logic inv);
		logic signed [W:0] d;
		d = {a[W-1], a} - {c[W-1], c};
		if (inv) begin
			d = -d;
		end
		return d[W-1:0];
	endfunction

	function automatic logic [W-1:0] mag_of(input logic signed [W-1:0] c);
		logic signed [W:0] t;
		t = {c[W-1], c};
		if (t < 0) begin
			t = -t;
		end
		return t[W-1:0];
	endfunction

	// triangle at corner c between neighbours a and b
	function automatic logic [LW-1:0] tri_ops(input logic signed [W-1:0] a,
		input logic signed [W-1:0] c, input logic signed [W-1:0] b, input logic inv);
		logic [W-1:0] m;
		m = mag_of(c);
		return {m, m, {(2*W){1'b0}}, edge_len(a, c, inv), edge_len(b, c, inv)};
	endfunction

	// trapezoid with inside corners c1, c2 and outside partners a1, a2
	function automatic logic [LW-1:0] trap_ops(input logic signed [W-1:0] a1,
		input logic signed [W-1:0] a2, input logic signed [W-1:0] c1,
		input logic signed [W-1:0] c2);
		logic [W-1:0] e1;
		logic [W-1:0] e2;
		e1 = edge_len(a1, c1, 1'b0);
		e2 = edge_len(a2, c2, 1'b0);
		return {mag_of(c1), e2, mag_of(c2), e1, e1, e2};
	endfunction

	logic signed [W-1:0] tl, tr, bl, br;
	logic [3:0] mask;
	logic [LW-1:0] ops_a, ops_b, null_ops;
	caf_res_kind_t kind;
	logic accept;
	logic v_s1;
	logic [QW-1:0] item_s1;

	assign tl = cell_in.dist_top_left;
	assign tr = cell_in.dist_top_right;
	assign bl = cell_in.dist_bottom_left;
	assign br = cell_in.dist_bottom_right;
	assign mask = {bl[W-1], br[W-1], tr[W-1], tl[W-1]};
	// zero numerator over a unit denominator gives a zero quotient
	assign null_ops = {{(4*W){1'b0}}, ONE_W, ONE_W};

	// case selection on the inside mask
	always_comb begin
		ops_a = null_ops;
		ops_b = null_ops;
		kind = CAF_RK_SUM;
		unique case (mask)
			4'b0000: kind = CAF_RK_ZERO;
			4'b1111: kind = CAF_RK_FULL;
			4'b0001: ops_a = tri_ops(bl, tl, tr, 1'b0);
			4'b0010: ops_a = tri_ops(tl, tr, br, 1'b0);
			4'b0100: ops_a = tri_ops(tr, br, bl, 1'b0);
			4'b1000: ops_a = tri_ops(br, bl, tl, 1'b0);
			4'b1110: begin
				ops_a = tri_ops(bl, tl, tr, 1'b1);
				kind = CAF_RK_INV;
			end
			4'b1101: begin
				ops_a = tri_ops(tl, tr, br, 1'b1);
				kind = CAF_RK_INV;
			end
			4'b1011: begin
				ops_a = tri_ops(tr, br, bl, 1'b1);
				kind = CAF_RK_INV;
			end
			4'b0111: begin
				ops_a = tri_ops(br, bl, tl, 1'b1);
				kind = CAF_RK_INV;
			end
			4'b0011: ops_a = trap_ops(bl, br, tl, tr);
			4'b0110: ops_a = trap_ops(tl, bl, tr, br);
			4'b1001: ops_a = trap_ops(tr, br, tl, bl);
			4'b1100: ops_a = trap_ops(tl, tr, bl, br);
			4'b0101: begin
				ops_a = tri_ops(bl, tl, tr, 1'b0);
				ops_b = tri_ops(tr, br, bl, 1'b0);
			end
			4'b1010: begin
				ops_a = tri_ops(tl, tr, br, 1'b0);
				ops_b = tri_ops(br, bl, tl, 1'b0);
			end
			default: kind = CAF_RK_ZERO;
		endcase
	end

	// handshake: hold one classified item until the queue takes it
	assign cell_in.ready = !v_s1 || !qstat.full;
	assign accept = cell_in.valid && cell_in.ready;
	assign push = v_s1 && !qstat.full;
	assign item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (push) begin
			v_s1 <= 1'b0;
		end
	end

	// classified item register
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= {ops_a, ops_b, kind};
		end
	end

endmodule

>>> rtl/core/caf_queue.sv
// small first-in first-out queue between front end and back end
`timescale 1ns / 1ps

module caf_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = caf_pkg::CAF_QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  logic [WIDTH-1:0] din,
	input  logic pop,
	output logic [WIDTH-1:0] dout,
	output caf_pkg::caf_qstat_t qstat
);
	import caf_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0] wptr_q, rptr_q;
	logic [CW-1:0] cnt_q;

	assign dout = mem_q[rptr_q];
	assign qstat.full = (cnt_q == CW'(DEPTH));
	assign qstat.empty = (cnt_q == '0);

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == LAST) ? '0 : wptr_q + AW'(1);
			end
			if (pop) begin
				rptr_q <= (rptr_q == LAST) ? '0 : rptr_q + AW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= din;
		end
	end

endmodule

>>> rtl/core/caf_back.sv
// back end: products, pipelined restoring division in two lanes, result combine
`timescale 1ns / 1ps

module caf_back #(
	parameter int DIST_WIDTH = caf_pkg::CAF_DIST_WIDTH,
	parameter int FRAC_BITS = caf_pkg::CAF_FRAC_BITS
) (
	input  logic clk,
	input  logic arst_n,
	input  caf_pkg::caf_qstat_t qstat,
	input  logic [2*caf_pkg::CAF_LANE_OPS*DIST_WIDTH+$bits(caf_pkg::caf_res_kind_t)-1:0] head,
	output logic pop,
	caf_out_if.source cov_out
);
	import caf_pkg::*;

	localparam int W = DIST_WIDTH;
	localparam int F = FRAC_BITS;
	localparam int LW = CAF_LANE_OPS * W;
	localparam int KW = $bits(caf_res_kind_t);
	localparam int QW = 2 * LW + KW;
	localparam int PW = 2 * W;
	localparam int XW = 2 * W + 1;
	localparam int NW = 2 * W + F + 2;
	localparam int CW = F + 1;
	localparam int DS = F + 1;
	localparam logic [CW-1:0] COV_ONE = CW'(1) << F;

	logic en;
	logic [LW-1:0] ops [2];
	logic vld_s2;
	caf_res_kind_t kind_s2;
	logic [PW-1:0] p1_s2 [2];
	logic [PW-1:0] p2_s2 [2];
	logic [PW-1:0] pp_s2 [2];
	logic vld_s4 [DS+1];
	caf_res_kind_t kind_s4 [DS+1];
	logic [NW-1:0] rem_s4 [2][DS+1];
	logic [PW:0] den_s4 [2][DS+1];
	logic [CW-1:0] quo_s4 [2][DS+1];
	logic [CW-1:0] qa, qb, res;
	logic [CW:0] qsum;
	logic out_vld_q;
	logic [CW-1:0] cov_q;

	// the whole back pipeline moves unless the output item is stalled
	assign en = !out_vld_q || cov_out.ready;
	assign pop = en && !qstat.empty;
	assign ops[0] = head[QW-1 -: LW];
	assign ops[1] = head[LW+KW-1 -: LW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s4[0] <= 1'b0;
		end else if (en) begin
			vld_s2 <= !qstat.empty;
			vld_s4[0] <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s2 <= caf_res_kind_t'(head[KW-1:0]);
			kind_s4[0] <= kind_s2;
		end
	end

	// per-lane products, numerator and denominator
	for (genvar ln = 0; ln < 2; ln++) begin : g_lane
		logic [XW-1:0] xsum;
		assign xsum = XW'(p1_s2[ln]) + XW'(p2_s2[ln]);

		always_ff @(posedge clk) begin
			if (en) begin
				p1_s2[ln] <= PW'(ops[ln][6*W-1 -: W]) * PW'(ops[ln][5*W-1 -: W]);
				p2_s2[ln] <= PW'(ops[ln][4*W-1 -: W]) * PW'(ops[ln][3*W-1 -: W]);
				pp_s2[ln] <= PW'(ops[ln][2*W-1 -: W]) * PW'(ops[ln][W-1:0]);
				rem_s4[ln][0] <= (NW'(xsum) << F) + NW'(pp_s2[ln]);
				den_s4[ln][0] <= {pp_s2[ln], 1'b0};
				quo_s4[ln][0] <= '0;
			end
		end

		// one quotient bit per stage, most significant first
		for (genvar k = 0; k < DS; k++) begin : g_div
			logic [NW-1:0] shifted;
			logic ge;
			assign shifted = NW'(den_s4[ln][k]) << (F - k);
			assign ge = (rem_s4[ln][k] >= shifted);

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s4[ln][k+1] <= ge ? rem_s4[ln][k] - shifted : rem_s4[ln][k];
					den_s4[ln][k+1] <= den_s4[ln][k];
					quo_s4[ln][k+1] <= {quo_s4[ln][k][CW-2:0], ge};
				end
			end
		end
	end

	// valid and kind follow the divider stages
	for (genvar k = 0; k < DS; k++) begin : g_ctl
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s4[k+1] <= 1'b0;
			end else if (en) begin
				vld_s4[k+1] <= vld_s4[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				kind_s4[k+1] <= kind_s4[k];
			end
		end
	end

	// combine the lane quotients and saturate to one
	assign qa = quo_s4[0][DS];
	assign qb = quo_s4[1][DS];
	assign qsum = (CW+1)'(qa) + (CW+1)'(qb);

	always_comb begin
		unique case (kind_s4[DS])
			CAF_RK_SUM:  res = (qsum > (CW+1)'(COV_ONE)) ? COV_ONE : qsum[CW-1:0];
			CAF_RK_INV:  res = (qa > COV_ONE) ? '0 : COV_ONE - qa;
			CAF_RK_ZERO: res = '0;
			CAF_RK_FULL: res = COV_ONE;
			default:     res = '0;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= vld_s4[DS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cov_q <= res;
		end
	end

	assign cov_out.valid = out_vld_q;
	assign cov_out.coverage = cov_q;

endmodule

>>> rtl/core/cell_area_fraction_unit.sv
// top level of the cell area fraction block
//
//   channel   direction  payload                                   width each
//   cell_in   in         dist_top_left/top_right/bottom_left/right  DIST_WIDTH, signed
//   cov_out   out        coverage                                  FRAC_BITS+1, unsigned
//
// one item per cycle sustained while the output is not stalled; after the accepting edge the
// item passes through classify, queue, products, numerator, FRAC_BITS+1 divider stages and
// the output register
// the divider is a row of FRAC_BITS+1 restoring stages in each of two lanes
// reset clears all valid flags and the queue pointers, no clearing pass
// a stalled output freezes the back pipeline; the queue keeps the input side moving until full
`timescale 1ns / 1ps

module cell_area_fraction_unit #(
	parameter int DIST_WIDTH = caf_pkg::CAF_DIST_WIDTH,
	parameter int FRAC_BITS = caf_pkg::CAF_FRAC_BITS
) (
	input  logic clk,
	input  logic arst_n,
	caf_in_if.sink cell_in,
	caf_out_if.source cov_out
);
	import caf_pkg::*;

	localparam int QW = 2 * CAF_LANE_OPS * DIST_WIDTH + $bits(caf_res_kind_t);
	localparam logic [FRAC_BITS:0] COV_ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

	logic push, pop;
	logic [QW-1:0] front_item, head_item;
	caf_qstat_t qstat;

	caf_front #(.DIST_WIDTH(DIST_WIDTH)) u_front (
		.clk(clk), .arst_n(arst_n), .cell_in(cell_in),
		.qstat(qstat), .push(push), .item(front_item)
	);

	caf_queue #(.WIDTH(QW), .DEPTH(CAF_QUEUE_DEPTH)) u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .din(front_item),
		.pop(pop), .dout(head_item), .qstat(qstat)
	);

	caf_back #(.DIST_WIDTH(DIST_WIDTH), .FRAC_BITS(FRAC_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .qstat(qstat), .head(head_item),
		.pop(pop), .cov_out(cov_out)
	);

	// coverage never exceeds one
	a_cov_range: assert property (@(posedge clk) disable iff (!arst_n)
		cov_out.valid |-> (cov_out.coverage <= COV_ONE))
		else $error("coverage above one");

	// front end never writes a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !qstat.full)
		else $error("queue overflow");

	// back end never reads an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qstat.empty)
		else $error("queue underflow");

	// a stalled output item is not dropped by the back pipeline
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(cov_out.valid && !cov_out.ready) |=> cov_out.valid)
		else $error("stalled item lost");

endmodule

>>> dv/tb.sv
// self-checking testbench for the cell area fraction block
`timescale 1ns / 1ps

module tb;
	import caf_pkg::*;

	localparam int DW = CAF_DIST_WIDTH;
	localparam int FB = CAF_FRAC_BITS;
	localparam int CW = FB + 1;
	localparam logic [CW-1:0] COV_FULL = CW'(1) << FB;
	localparam longint DMAX = (longint'(1) << (DW - 1)) - 1;
	localparam longint DMIN = -(longint'(1) << (DW - 1));

	// corner bits of the inside mask
	localparam logic [3:0] IN_TL = 4'b0001;
	localparam logic [3:0] IN_TR = 4'b0010;
	localparam logic [3:0] IN_BR = 4'b0100;
	localparam logic [3:0] IN_BL = 4'b1000;

	typedef logic signed [DW-1:0] dist_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int errors = 0;
	logic [CW-1:0] cov_expected_q[$];

	caf_in_if cell_ch ();
	caf_out_if cov_ch ();

	cell_area_fraction_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.cell_in(cell_ch),
		.cov_out(cov_ch)
	);

	always #5 clk = ~clk;

	// x / (2p) scaled to the fraction, rounded to nearest with ties up
	function automatic logic [127:0] scaled_quot(logic [127:0] x, logic [127:0] p);
		if (p == 0)
			return 0;
		return ((x << FB) + p) / (p << 1);
	endfunction

	function automatic logic [127:0] mag128(longint v);
		return (v < 0) ? 128'(-v) : 128'(v);
	endfunction

	// triangle at inside corner c between neighbours a and b
	function automatic logic [127:0] triangle(longint a, longint c, longint b);
		logic [127:0] m;
		m = mag128(c);
		return scaled_quot(m * m, 128'(a - c) * 128'(b - c));
	endfunction

	// trapezoid with inside corners c1, c2 and outside partners a1, a2
	function automatic logic [127:0] trapezoid(longint a1, longint a2, longint c1, longint c2);
		logic [127:0] e1, e2;
		e1 = 128'(a1 - c1);
		e2 = 128'(a2 - c2);
		return scaled_quot(mag128(c1) * e2 + mag128(c2) * e1, e1 * e2);
	endfunction

	function automatic logic [127:0] inv_triangle(longint a, longint c, longint b);
		logic [127:0] t;
		t = triangle(-a, -c, -b);
		return (t > COV_FULL) ? 0 : COV_FULL - t;
	endfunction

	function automatic logic [CW-1:0] predict_coverage(dist_t dtl, dist_t dtr, dist_t dbl,
			dist_t dbr);
		longint tl, tr, bl, br;
		logic [3:0] m;
		logic [127:0] r;
		tl = dtl; tr = dtr; bl = dbl; br = dbr;
		m = (tl < 0 ? IN_TL : 4'b0) | (tr < 0 ? IN_TR : 4'b0) |
			(br < 0 ? IN_BR : 4'b0) | (bl < 0 ? IN_BL : 4'b0);
		case (m)
			IN_TL: r = triangle(bl, tl, tr);
			IN_TR: r = triangle(tl, tr, br);
			IN_BR: r = triangle(tr, br, bl);
			IN_BL: r = triangle(br, bl, tl);
			IN_TR | IN_BR | IN_BL: r = inv_triangle(bl, tl, tr);
			IN_TL | IN_BR | IN_BL: r = inv_triangle(tl, tr, br);
			IN_TL | IN_TR | IN_BL: r = inv_triangle(tr, br, bl);
			IN_TL | IN_TR | IN_BR: r = inv_triangle(br, bl, tl);
			IN_TL | IN_TR: r = trapezoid(bl, br, tl, tr);
			IN_TR | IN_BR: r = trapezoid(tl, bl, tr, br);
			IN_TL | IN_BL: r = trapezoid(tr, br, tl, bl);
			IN_BR | IN_BL: r = trapezoid(tl, tr, bl, br);
			IN_TL | IN_BR: r = triangle(bl, tl, tr) + triangle(tr, br, bl);
			IN_TR | IN_BL: r = triangle(tl, tr, br) + triangle(br, bl, tl);
			IN_TL | IN_TR | IN_BR | IN_BL: r = COV_FULL;
			default: r = 0;
		endcase
		if (r > COV_FULL)
			r = COV_FULL;
		return r[CW-1:0];
	endfunction

	// send one cell item, keeping valid high across back-to-back items
	task automatic send_cell(dist_t tl, dist_t tr, dist_t bl, dist_t br);
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			cell_ch.valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct)
				@(posedge clk);
		end
		cell_ch.valid <= 1'b1;
		cell_ch.dist_top_left <= tl;
		cell_ch.dist_top_right <= tr;
		cell_ch.dist_bottom_left <= bl;
		cell_ch.dist_bottom_right <= br;
		@(posedge clk);
		while (!cell_ch.ready)
			@(posedge clk);
		cov_expected_q.push_back(predict_coverage(tl, tr, bl, br));
	endtask

	// one corner distance, inside (negative) or outside (zero or above)
	function automatic dist_t rand_corner(bit in_shape);
		longint v;
		int sel;
		sel = $urandom_range(99);
		if (sel < 45)
			v = $urandom_range(1 << (FB + 1), 1);
		else if (sel < 80)
			v = $urandom_range(DMAX, 1);
		else if (sel < 90)
			v = $urandom_range(8, 1);
		else
			v = DMAX;
		if (in_shape)
			return (sel >= 95) ? dist_t'(DMIN) : dist_t'(-v);
		return (sel >= 85 && sel < 90) ? dist_t'(0) : dist_t'(v);
	endfunction

	// receiver backpressure
	always @(posedge clk) begin
		cov_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// compare each coverage item with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && cov_ch.valid && cov_ch.ready) begin
			if (cov_expected_q.size() == 0) begin
				$display("%0t: unexpected coverage item %0d", $time, cov_ch.coverage);
				errors++;
			end else begin
				if (cov_ch.coverage !== cov_expected_q[0]) begin
					$display("%0t: coverage mismatch expected %0d actual %0d", $time,
						cov_expected_q[0], cov_ch.coverage);
					errors++;
				end
				void'(cov_expected_q.pop_front());
			end
		end
	end

	// every mask case with extreme and boundary distances
	task automatic test_directed();
		send_cell(0, 0, 0, 0);
		send_cell(-1, -1, -1, -1);
		send_cell(dist_t'(DMIN), dist_t'(DMIN), dist_t'(DMIN), dist_t'(DMIN));
		send_cell(dist_t'(DMAX), dist_t'(DMAX), dist_t'(DMAX), dist_t'(DMAX));
		send_cell(dist_t'(DMIN), dist_t'(DMAX), dist_t'(DMAX), dist_t'(DMAX));
		send_cell(-1, 0, 0, 0);
		send_cell(0, dist_t'(DMIN), 0, 0);
		send_cell(65536, 65536, 65536, -65536);
		send_cell(dist_t'(DMAX), dist_t'(DMAX), dist_t'(DMIN), dist_t'(DMAX));
		send_cell(0, dist_t'(DMIN), dist_t'(DMIN), dist_t'(DMIN));
		send_cell(dist_t'(DMIN), 0, dist_t'(DMIN), dist_t'(DMIN));
		send_cell(-1, -1, 0, -1);
		send_cell(dist_t'(DMIN), dist_t'(DMIN), -1, dist_t'(DMAX));
		send_cell(-32768, -32768, 32768, 32768);
		send_cell(dist_t'(DMAX), -5, dist_t'(DMAX), -5);
		send_cell(-100, 100, -100, 100);
		send_cell(0, 0, dist_t'(DMIN), dist_t'(DMIN));
		send_cell(dist_t'(DMIN), 1, 1, dist_t'(DMIN));
		send_cell(1, dist_t'(DMIN), dist_t'(DMIN), 1);
		send_cell(-65536, 0, 0, -65536);
		send_cell(0, -1, -1, 0);
	endtask

	// random cells under one setting of sender idling and receiver stalls
	task automatic test_random(int count, int idle_pct, int stall_pct);
		logic [3:0] m;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		repeat (count) begin
			m = $urandom_range(15);
			send_cell(rand_corner(m[0]), rand_corner(m[1]), rand_corner(m[3]),
				rand_corner(m[2]));
		end
	endtask

	initial begin
		cell_ch.valid = 1'b0;
		cell_ch.dist_top_left = '0;
		cell_ch.dist_top_right = '0;
		cell_ch.dist_bottom_left = '0;
		cell_ch.dist_bottom_right = '0;
		cov_ch.ready = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(400, 0, 0);
		test_random(400, 81, 0);
		test_random(400, 0, 81);
		test_random(400, 13, 13);
		cell_ch.valid <= 1'b0;
		while (cov_expected_q.size() != 0)
			@(posedge clk);
		repeat (FB + 20) @(posedge clk);
		if (errors == 0 && cov_expected_q.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// run time limit
	initial begin
		#20ms;
		$display("TEST FAILED");
		$finish;
	end

endmodule
